// File: rtl/twpt_pkg.sv
// ----------------------------------------------------------------------------
// twpt_pkg
// Shared types, constants and the arctangent table for the twist transform.
// ----------------------------------------------------------------------------
package twpt_pkg;

    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PHASE_W      = 30;
    localparam int TRIG_W       = 32;
    localparam int INT_STEPS    = DIFF_W;
    localparam int DIV_STEPS    = INT_STEPS + PHASE_W;
    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_SHIFT   = 29;
    localparam int INDEX_W      = 3;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd326016437;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [INDEX_W-1:0] REG_AXIS     = 3'd0;
    localparam logic [INDEX_W-1:0] REG_PITCH    = 3'd1;
    localparam logic [INDEX_W-1:0] REG_ORIGIN_X = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ORIGIN_Y = 3'd3;
    localparam logic [INDEX_W-1:0] REG_ORIGIN_Z = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        point_t                   pt;
        logic signed [DIFF_W-1:0] dp;
        logic signed [DIFF_W-1:0] dq;
        logic                     bypass;
    } carry_t;

    function automatic logic signed [TRIG_W-1:0] atan_turn(input int unsigned i);
        logic signed [TRIG_W-1:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/twpt_phase_div.sv
// ----------------------------------------------------------------------------
// twpt_phase_div
// Pipelined restoring divider: one quotient bit per stage, yields the floor
// turn phase of axial offset over pitch, reduced to one turn.
// ----------------------------------------------------------------------------
module twpt_phase_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  twpt_pkg::carry_t                in_carry,
    input  logic [twpt_pkg::DIFF_W-1:0]     dmag,
    input  logic                            neg,
    input  logic [twpt_pkg::COORD_W-1:0]    pmag,
    output logic                            out_valid,
    output twpt_pkg::carry_t                out_carry,
    output logic [twpt_pkg::TRIG_W-1:0]     phase
);
    import twpt_pkg::*;

    logic                 valid_reg [0:DIV_STEPS-1];
    logic [COORD_W-1:0]   rem_reg   [0:DIV_STEPS-1];
    logic [PHASE_W-1:0]   ql_reg    [0:DIV_STEPS-1];
    logic [DIFF_W-1:0]    dmag_reg  [0:DIV_STEPS-1];
    logic                 neg_reg   [0:DIV_STEPS-1];
    carry_t               carry_reg [0:DIV_STEPS-1];

    logic [PHASE_W-1:0]   q_last;

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic               v_s;
            logic [COORD_W-1:0] rem_s;
            logic [PHASE_W-1:0] ql_s;
            logic [DIFF_W-1:0]  dm_s;
            logic               ng_s;
            carry_t             cy_s;
            logic               nb;
            logic [COORD_W:0]   trial;
            logic               ge;
            logic [COORD_W-1:0] rem_next;
            logic [PHASE_W-1:0] ql_next;

            if (k == 0)
            begin : g_first
                assign v_s   = in_valid;
                assign rem_s = '0;
                assign ql_s  = '0;
                assign dm_s  = dmag;
                assign ng_s  = neg;
                assign cy_s  = in_carry;
            end
            else
            begin : g_rest
                assign v_s   = valid_reg[k-1];
                assign rem_s = rem_reg[k-1];
                assign ql_s  = ql_reg[k-1];
                assign dm_s  = dmag_reg[k-1];
                assign ng_s  = neg_reg[k-1];
                assign cy_s  = carry_reg[k-1];
            end

            if (k < INT_STEPS)
            begin : g_int
                assign nb      = dm_s[INT_STEPS-1-k];
                assign ql_next = ql_s;
            end
            else
            begin : g_frac
                assign nb      = 1'b0;
                assign ql_next = {ql_s[PHASE_W-2:0], ge};
            end

            assign trial    = {rem_s, nb};
            assign ge       = (trial >= {1'b0, pmag});
            assign rem_next = ge ? COORD_W'(trial - {1'b0, pmag}) : trial[COORD_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= v_s;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]   <= rem_next;
                    ql_reg[k]    <= ql_next;
                    dmag_reg[k]  <= dm_s;
                    neg_reg[k]   <= ng_s;
                    carry_reg[k] <= cy_s;
                end
            end
        end
    endgenerate

    // floor: a negative quotient with a remainder steps down by one
    always_comb
    begin
        if (!neg_reg[DIV_STEPS-1])
        begin
            q_last = ql_reg[DIV_STEPS-1];
        end
        else if (rem_reg[DIV_STEPS-1] != '0)
        begin
            q_last = ~ql_reg[DIV_STEPS-1];
        end
        else
        begin
            q_last = PHASE_W'(-ql_reg[DIV_STEPS-1]);
        end
    end

    assign phase     = {q_last, 2'b00};
    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_carry = carry_reg[DIV_STEPS-1];

endmodule

// File: rtl/twpt_cordic.sv
// ----------------------------------------------------------------------------
// twpt_cordic
// Pipelined CORDIC in rotation mode: one micro-rotation per stage, giving
// cosine and sine in Q2.29 of a 32-bit turn angle.
// ----------------------------------------------------------------------------
module twpt_cordic
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  twpt_pkg::carry_t                    in_carry,
    input  logic [twpt_pkg::TRIG_W-1:0]         phase,
    output logic                                out_valid,
    output twpt_pkg::carry_t                    out_carry,
    output logic signed [twpt_pkg::TRIG_W-1:0]  cos_val,
    output logic signed [twpt_pkg::TRIG_W-1:0]  sin_val
);
    import twpt_pkg::*;

    localparam logic signed [TRIG_W-1:0] QUARTER = 32'sh40000000;
    localparam logic signed [TRIG_W-1:0] HALF    = 32'sh80000000;

    logic                     valid_reg [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] x_reg     [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] y_reg     [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] z_reg     [0:CORDIC_STEPS];
    logic                     flip_reg  [0:CORDIC_STEPS];
    carry_t                   carry_reg [0:CORDIC_STEPS];

    logic signed [TRIG_W-1:0] z_fold;
    logic                     flip_next;

    // fold into the right half-plane and remember to negate
    always_comb
    begin
        z_fold    = signed'(phase);
        flip_next = 1'b0;
        if (signed'(phase) > QUARTER)
        begin
            z_fold    = TRIG_W'(signed'(phase) - HALF);
            flip_next = 1'b1;
        end
        else if (signed'(phase) < -QUARTER)
        begin
            z_fold    = TRIG_W'(signed'(phase) + HALF);
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]     <= CORDIC_GAIN;
            y_reg[0]     <= '0;
            z_reg[0]     <= z_fold;
            flip_reg[0]  <= flip_next;
            carry_reg[0] <= in_carry;
        end
    end

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++)
        begin : g_rot
            logic signed [TRIG_W-1:0] dx;
            logic signed [TRIG_W-1:0] dy;
            logic signed [TRIG_W-1:0] x_next;
            logic signed [TRIG_W-1:0] y_next;
            logic signed [TRIG_W-1:0] z_next;

            assign dx = y_reg[k] >>> k;
            assign dy = x_reg[k] >>> k;

            always_comb
            begin
                if (!z_reg[k][TRIG_W-1])
                begin
                    x_next = x_reg[k] - dx;
                    y_next = y_reg[k] + dy;
                    z_next = z_reg[k] - atan_turn(k);
                end
                else
                begin
                    x_next = x_reg[k] + dx;
                    y_next = y_reg[k] - dy;
                    z_next = z_reg[k] + atan_turn(k);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k+1] <= valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k+1]     <= x_next;
                    y_reg[k+1]     <= y_next;
                    z_reg[k+1]     <= z_next;
                    flip_reg[k+1]  <= flip_reg[k];
                    carry_reg[k+1] <= carry_reg[k];
                end
            end
        end
    endgenerate

    assign cos_val   = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign sin_val   = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_carry = carry_reg[CORDIC_STEPS];

endmodule

// File: rtl/axis_twist_point_transform.sv
// ----------------------------------------------------------------------------
// axis_twist_point_transform
// Twists a Q15.16 point about the X, Y or Z axis through a set origin.
// Pipeline: input register, 63 divider stages, 31 CORDIC stages,
// multiply, round and saturate/output register.
// Throughput: one point per cycle; the whole pipeline holds while a result
// waits at the output.
// Reset clears every valid bit and loads axis Z, zero pitch, zero origin.
// ----------------------------------------------------------------------------
module axis_twist_point_transform
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [3*twpt_pkg::COORD_W-1:0]      s_tdata,  // point_x, point_y, point_z
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [3*twpt_pkg::COORD_W-1:0]      m_tdata,  // twisted_x, twisted_y, twisted_z
    input  logic                                cfg_we,
    input  logic [twpt_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [twpt_pkg::COORD_W-1:0]        cfg_data
);
    import twpt_pkg::*;

    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W - TRIG_SHIFT;
    localparam int OUT_W  = RND_W + 1;
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (TRIG_SHIFT - 1);
    localparam logic signed [OUT_W-1:0] SAT_HI  = OUT_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [OUT_W-1:0] SAT_LO  = -SAT_HI - OUT_W'(1);

    logic [1:0]                 axis_reg;
    logic signed [COORD_W-1:0]  pitch_reg;
    logic signed [COORD_W-1:0]  origin_x_reg;
    logic signed [COORD_W-1:0]  origin_y_reg;
    logic signed [COORD_W-1:0]  origin_z_reg;

    logic                       en;
    logic                       in_valid_reg;
    point_t                     in_pt_reg;

    carry_t                     carry0;
    logic signed [DIFF_W-1:0]   da;
    logic [DIFF_W-1:0]          dmag;
    logic [COORD_W-1:0]         pmag;
    logic                       neg;

    logic                       div_valid;
    carry_t                     div_carry;
    logic [TRIG_W-1:0]          phase;

    logic                       cor_valid;
    carry_t                     cor_carry;
    logic signed [TRIG_W-1:0]   cos_val;
    logic signed [TRIG_W-1:0]   sin_val;

    logic                       mul_valid_reg;
    carry_t                     mul_carry_reg;
    logic signed [PROD_W-1:0]   pc_reg;
    logic signed [PROD_W-1:0]   qs_reg;
    logic signed [PROD_W-1:0]   ps_reg;
    logic signed [PROD_W-1:0]   qc_reg;

    logic                       sum_valid_reg;
    carry_t                     sum_carry_reg;
    logic signed [RND_W-1:0]    rp_reg;
    logic signed [RND_W-1:0]    rq_reg;
    logic signed [SUM_W-1:0]    sp_next;
    logic signed [SUM_W-1:0]    sq_next;

    logic                       out_valid_reg;
    point_t                     out_pt_reg;
    point_t                     out_pt_next;
    logic signed [COORD_W-1:0]  org_p;
    logic signed [COORD_W-1:0]  org_q;
    logic signed [COORD_W-1:0]  sat_p;
    logic signed [COORD_W-1:0]  sat_q;

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [RND_W-1:0]   v,
        input logic signed [COORD_W-1:0] o
    );
        logic signed [OUT_W-1:0] s;
        s = OUT_W'(v) + OUT_W'(o);
        if (s > SAT_HI)
        begin
            return SAT_HI[COORD_W-1:0];
        end
        if (s < SAT_LO)
        begin
            return SAT_LO[COORD_W-1:0];
        end
        return s[COORD_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg     <= AXIS_Z;
            pitch_reg    <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AXIS:     axis_reg     <= cfg_data[1:0];
                REG_PITCH:    pitch_reg    <= cfg_data;
                REG_ORIGIN_X: origin_x_reg <= cfg_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg  <= s_tvalid;
            mul_valid_reg <= cor_valid;
            sum_valid_reg <= mul_valid_reg;
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_pt_reg <= point_t'(s_tdata);
        end
    end

    // pick axial offset and the rotated pair
    always_comb
    begin
        carry0.pt     = in_pt_reg;
        carry0.bypass = (pitch_reg == '0);
        unique case (axis_reg)
            AXIS_X:
            begin
                da        = DIFF_W'(in_pt_reg.x) - DIFF_W'(origin_x_reg);
                carry0.dp = DIFF_W'(in_pt_reg.y) - DIFF_W'(origin_y_reg);
                carry0.dq = DIFF_W'(in_pt_reg.z) - DIFF_W'(origin_z_reg);
            end
            AXIS_Y:
            begin
                da        = DIFF_W'(in_pt_reg.y) - DIFF_W'(origin_y_reg);
                carry0.dp = DIFF_W'(in_pt_reg.z) - DIFF_W'(origin_z_reg);
                carry0.dq = DIFF_W'(in_pt_reg.x) - DIFF_W'(origin_x_reg);
            end
            AXIS_Z:
            begin
                da        = DIFF_W'(in_pt_reg.z) - DIFF_W'(origin_z_reg);
                carry0.dp = DIFF_W'(in_pt_reg.x) - DIFF_W'(origin_x_reg);
                carry0.dq = DIFF_W'(in_pt_reg.y) - DIFF_W'(origin_y_reg);
            end
            default:
            begin
                da            = '0;
                carry0.dp     = '0;
                carry0.dq     = '0;
                carry0.bypass = 1'b1;
            end
        endcase
    end

    assign dmag = da[DIFF_W-1] ? DIFF_W'(-da) : DIFF_W'(da);
    assign pmag = pitch_reg[COORD_W-1] ? COORD_W'(-pitch_reg) : COORD_W'(pitch_reg);
    assign neg  = da[DIFF_W-1] ^ pitch_reg[COORD_W-1];

    twpt_phase_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_carry  (carry0),
        .dmag      (dmag),
        .neg       (neg),
        .pmag      (pmag),
        .out_valid (div_valid),
        .out_carry (div_carry),
        .phase     (phase)
    );

    twpt_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_carry  (div_carry),
        .phase     (phase),
        .out_valid (cor_valid),
        .out_carry (cor_carry),
        .cos_val   (cos_val),
        .sin_val   (sin_val)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_carry_reg <= cor_carry;
            pc_reg        <= PROD_W'(cor_carry.dp) * PROD_W'(cos_val);
            qs_reg        <= PROD_W'(cor_carry.dq) * PROD_W'(sin_val);
            ps_reg        <= PROD_W'(cor_carry.dp) * PROD_W'(sin_val);
            qc_reg        <= PROD_W'(cor_carry.dq) * PROD_W'(cos_val);
        end
    end

    assign sp_next = SUM_W'(pc_reg) - SUM_W'(qs_reg) + RND_HALF;
    assign sq_next = SUM_W'(ps_reg) + SUM_W'(qc_reg) + RND_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_carry_reg <= mul_carry_reg;
            rp_reg        <= sp_next[SUM_W-1:TRIG_SHIFT];
            rq_reg        <= sq_next[SUM_W-1:TRIG_SHIFT];
        end
    end

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                org_p = origin_y_reg;
                org_q = origin_z_reg;
            end
            AXIS_Y:
            begin
                org_p = origin_z_reg;
                org_q = origin_x_reg;
            end
            default:
            begin
                org_p = origin_x_reg;
                org_q = origin_y_reg;
            end
        endcase
    end

    assign sat_p = sat_add(rp_reg, org_p);
    assign sat_q = sat_add(rq_reg, org_q);

    always_comb
    begin
        out_pt_next = sum_carry_reg.pt;
        if (!sum_carry_reg.bypass)
        begin
            unique case (axis_reg)
                AXIS_X:
                begin
                    out_pt_next.y = sat_p;
                    out_pt_next.z = sat_q;
                end
                AXIS_Y:
                begin
                    out_pt_next.z = sat_p;
                    out_pt_next.x = sat_q;
                end
                AXIS_Z:
                begin
                    out_pt_next.x = sat_p;
                    out_pt_next.y = sat_q;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pt_reg <= out_pt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pt_reg;

    a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cor_valid && !cor_carry.bypass |->
            (cos_val <= 32'sh20000400) && (cos_val >= -32'sh20000400) &&
            (sin_val <= 32'sh20000400) && (sin_val >= -32'sh20000400))
        else $error("cosine or sine out of range");

    a_bypass_pass: assert property (@(posedge clk) disable iff (!rst_n)
        en && sum_valid_reg && sum_carry_reg.bypass |=>
            m_tvalid && (m_tdata == $past(sum_carry_reg.pt)))
        else $error("bypassed point altered");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for axis_twist_point_transform. A driver feeds points
// from a pending queue and a monitor checks every twisted point against a
// local fixed-point twist model. Register settings change between phases,
// with the pipeline drained, under several source and sink idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import twpt_pkg::*;

    localparam logic [1:0]         AXIS_NONE  = 2'd3;
    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd5;
    localparam int                 DRAIN      = 110;
    localparam int                 STALL_MAX  = 20000;

    localparam longint ATAN_TBL [CORDIC_STEPS] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [3*COORD_W-1:0]   s_tdata = '0;   // point_x, point_y, point_z
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [3*COORD_W-1:0]   m_tdata;        // twisted_x, twisted_y, twisted_z
    logic                   cfg_we = 1'b0;
    logic [INDEX_W-1:0]     cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data = '0;

    point_t pending_points [$];
    point_t twisted_due [$];

    logic [1:0] mdl_axis = AXIS_Z;
    longint     mdl_pitch = 0;
    longint     mdl_org [3] = '{0, 0, 0};

    int src_idle = 0;
    int snk_stall = 0;
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int quiet = 0;

    axis_twist_point_transform i_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic point_t twist_point(point_t p);
        longint pt [3];
        longint rs [3];
        longint d, num, q, r, z, x, y, dx, dy, dp, dq;
        logic [31:0] ph;
        bit flip;
        int a, ip, iq;
        point_t o;
        pt[0] = p.x;
        pt[1] = p.y;
        pt[2] = p.z;
        rs = pt;
        if (mdl_pitch != 0 && mdl_axis != AXIS_NONE)
        begin
            a = mdl_axis;
            ip = (a + 1) % 3;
            iq = (a + 2) % 3;
            d = pt[a] - mdl_org[a];
            num = d <<< PHASE_W;
            q = num / mdl_pitch;
            r = num % mdl_pitch;
            if (r != 0 && ((r < 0) != (mdl_pitch < 0)))
                q = q - 1;
            ph = {q[PHASE_W-1:0], 2'b00};
            z = longint'(ph);
            flip = 1'b0;
            if (z >= (64'sd1 << 31)) z = z - (64'sd1 << 32);
            if (z > (64'sd1 << 30))
            begin
                z = z - (64'sd1 << 31);
                flip = 1'b1;
            end
            else if (z < -(64'sd1 << 30))
            begin
                z = z + (64'sd1 << 31);
                flip = 1'b1;
            end
            x = CORDIC_GAIN;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TBL[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TBL[i];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            dp = pt[ip] - mdl_org[ip];
            dq = pt[iq] - mdl_org[iq];
            rs[ip] = sat_coord(((dp * x - dq * y + (64'sd1 << 28)) >>> TRIG_SHIFT)
                               + mdl_org[ip]);
            rs[iq] = sat_coord(((dp * y + dq * x + (64'sd1 << 28)) >>> TRIG_SHIFT)
                               + mdl_org[iq]);
        end
        o.x = rs[0][31:0];
        o.y = rs[1][31:0];
        o.z = rs[2][31:0];
        return o;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            twisted_due.push_back(twist_point(pending_points.pop_front()));
            sent++;
        end
        if (!s_tvalid || s_tready)
        begin
            if (rst_n && pending_points.size() > 0 && $urandom_range(99) >= src_idle)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_points[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        point_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (twisted_due.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end
            else
            begin
                want = twisted_due.pop_front();
                if (got.x !== want.x)
                begin
                    $error("twisted_x expected %h actual %h", want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y)
                begin
                    $error("twisted_y expected %h actual %h", want.y, got.y);
                    errors++;
                end
                if (got.z !== want.z)
                begin
                    $error("twisted_z expected %h actual %h", want.z, got.z);
                    errors++;
                end
            end
            checked++;
        end
        m_tready <= rst_n && ($urandom_range(99) >= snk_stall);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (pending_points.size() == 0 && twisted_due.size() == 0))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_AXIS:     mdl_axis = val[1:0];
            REG_PITCH:    mdl_pitch = longint'(signed'(val));
            REG_ORIGIN_X: mdl_org[0] = longint'(signed'(val));
            REG_ORIGIN_Y: mdl_org[1] = longint'(signed'(val));
            REG_ORIGIN_Z: mdl_org[2] = longint'(signed'(val));
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [1:0] ax, logic [31:0] pt, logic [31:0] ox,
                         logic [31:0] oy, logic [31:0] oz);
        write_reg(REG_AXIS, {30'd0, ax});
        write_reg(REG_PITCH, pt);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_points.push_back(p);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(255)
                                        : 32'h80000000 + $urandom_range(255);
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    task automatic drain();
        while (pending_points.size() > 0 || twisted_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
            add_point(rnd_coord(), rnd_coord(), rnd_coord());
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero pitch after reset: pass through
        add_point(32'h7FFFFFFF, 32'h80000000, 32'h00000000);
        add_point(32'hFFFFFFFF, 32'h00000001, 32'h80000000);
        drain();

        // quarter turn about Z, then far points to saturate
        setup(AXIS_Z, 32'h00040000, 32'h0, 32'h0, 32'h0);
        add_point(32'h00010000, 32'h00000000, 32'h00010000);
        add_point(32'h00010000, 32'h00020000, 32'h00020000);
        add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000);
        add_point(32'h80000000, 32'h7FFFFFFF, 32'h00030000);
        add_point(32'h80000000, 32'h80000000, 32'h80000000);
        add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        drain();

        setup(AXIS_X, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        add_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        add_point(32'h7FFFFFFF, 32'h00000000, 32'h00000000);
        add_point(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
        drain();

        setup(AXIS_Y, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        add_point(32'h00000000, 32'h00000000, 32'h00000000);
        drain();

        setup(AXIS_Y, 32'h00000001, 32'h0, 32'h0, 32'h0);
        add_point(32'h00010000, 32'h00000003, 32'h00020000);
        add_point(32'hFFFF0000, 32'h80000000, 32'h7FFFFFFF);
        drain();
        write_reg(REG_PITCH, 32'hFFFFFFFF);
        add_point(32'h00010000, 32'h00000005, 32'h00020000);
        drain();

        // meaningless axis selector and an out-of-range index
        write_reg(REG_AXIS, {30'd0, AXIS_NONE});
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        add_point(32'h11111111, 32'h22222222, 32'h33333333);
        add_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 77; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 77; end
                default: begin src_idle = 10; snk_stall = 10; end
            endcase
            setup(2'($urandom_range(2)),
                  $urandom_range(1) ? $urandom
                                    : 32'($signed($urandom_range(400000)) - 200000),
                  rnd_coord(), rnd_coord(), rnd_coord());
            random_burst(94);
        end

        $display("checked %0d twisted points of %0d sent, over all axes, pitch extremes,",
                 checked, sent);
        $display("bypass cases and four idling patterns");
        if (errors == 0 && twisted_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
